>>> sv/rcr_pkg.sv
// Shared types, codes and constants of the rectangle canvas rasterizer.
package rcr_pkg;

  localparam int unsigned MaxColsDef = 256;
  localparam int unsigned MaxRowsDef = 256;

  localparam int unsigned CfgW    = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CoordW  = 24;
  localparam int unsigned CalcW   = 27;
  localparam int unsigned FracBits = 8;
  localparam int unsigned PosW    = 8;

  localparam logic [CfgW-1:0]  WidthReset = 9'd1;
  localparam logic [CfgW-1:0]  HeightReset = 9'd1;
  localparam logic [CharW-1:0] BgReset = 8'd32;

  localparam logic signed [CalcW-1:0] FracOne = 27'sd256;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BACKGROUND    = 2'd2;

  // item action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_DRAW  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_REJECT  = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW,
    ST_READ,
    ST_DONE
  } state_e;

  // closed rectangle edges in 8-fraction-bit fixed point
  typedef struct packed {
    logic signed [CalcW-1:0] left;
    logic signed [CalcW-1:0] right;
    logic signed [CalcW-1:0] top;
    logic signed [CalcW-1:0] bottom;
  } bounds_t;

endpackage

>>> sv/rcr_canvas_mem.sv
// Character canvas memory: one port, synchronous write and registered read.
module rcr_canvas_mem #(
  parameter int unsigned AW = 16
) (
  input  logic                       clk_i,
  input  logic [AW-1:0]              addr_i,
  input  logic                       we_i,
  input  logic [rcr_pkg::CharW-1:0]  wdata_i,
  input  logic                       re_i,
  output logic [rcr_pkg::CharW-1:0]  rdata_o
);

  logic [rcr_pkg::CharW-1:0] mem_q [2**AW];
  logic [rcr_pkg::CharW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/rcr_cell_classify.sv
// Coverage test of one canvas cell against the latched rectangle.
module rcr_cell_classify #(
  parameter int unsigned CW = 8,
  parameter int unsigned RW = 8
) (
  input  logic [CW-1:0]       x_i,
  input  logic [RW-1:0]       y_i,
  input  rcr_pkg::bounds_t    bounds_i,
  input  logic                fill_i,
  output logic                paint_o
);

  logic signed [rcr_pkg::CalcW-1:0] px, py;
  logic signed [rcr_pkg::CalcW-1:0] px_lo, px_hi, py_lo, py_hi;
  logic inside_x, inside_y, band_x, band_y;

  // cell position scaled to fixed point, plus and minus one unit
  assign px = rcr_pkg::CalcW'(signed'({1'b0, x_i, {rcr_pkg::FracBits{1'b0}}}));
  assign py = rcr_pkg::CalcW'(signed'({1'b0, y_i, {rcr_pkg::FracBits{1'b0}}}));
  assign px_lo = px - rcr_pkg::FracOne;
  assign px_hi = px + rcr_pkg::FracOne;
  assign py_lo = py - rcr_pkg::FracOne;
  assign py_hi = py + rcr_pkg::FracOne;

  assign inside_x = (px >= bounds_i.left) && (px <= bounds_i.right);
  assign inside_y = (py >= bounds_i.top) && (py <= bounds_i.bottom);

  // less than one unit from an edge
  assign band_x = (px_lo < bounds_i.left) || (px_hi > bounds_i.right);
  assign band_y = (py_lo < bounds_i.top) || (py_hi > bounds_i.bottom);

  assign paint_o = inside_x && inside_y && (fill_i || band_x || band_y);

endmodule

>>> sv/rcr_walk_ctrl.sv
// Item sequencer: canvas walk, cell read, sticky error and result register.
module rcr_walk_ctrl #(
  parameter int unsigned CW = 8,
  parameter int unsigned RW = 8,
  localparam int unsigned AW = CW + RW
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_left_i,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_top_i,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_span_x_i,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_span_y_i,
  input  logic                               filled_i,
  input  logic [rcr_pkg::CharW-1:0]          paint_char_i,
  input  logic [rcr_pkg::PosW-1:0]           read_col_i,
  input  logic [rcr_pkg::PosW-1:0]           read_row_i,
  input  logic [CW-1:0]                      last_col_i,
  input  logic [RW-1:0]                      last_row_i,
  input  logic [rcr_pkg::CharW-1:0]          bg_char_i,
  output logic [CW-1:0]                      x_o,
  output logic [RW-1:0]                      y_o,
  output rcr_pkg::bounds_t                   bounds_o,
  output logic                               fill_o,
  input  logic                               paint_i,
  output logic [AW-1:0]                      mem_addr_o,
  output logic                               mem_we_o,
  output logic [rcr_pkg::CharW-1:0]          mem_wdata_o,
  output logic                               mem_re_o,
  input  logic [rcr_pkg::CharW-1:0]          mem_rdata_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rcr_pkg::CharW-1:0]          cell_char_o,
  output logic [1:0]                         status_o
);

  rcr_pkg::state_e state_q, state_d;
  logic [CW-1:0] x_q, x_d;
  logic [RW-1:0] y_q, y_d;
  logic err_q, err_d;
  logic out_valid_q, out_valid_d;
  rcr_pkg::bounds_t bounds_q, bounds_d;
  logic fill_q, fill_d;
  logic [rcr_pkg::CharW-1:0] pchar_q, pchar_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic rd_hit_q, rd_hit_d;
  logic [1:0] status_q, status_d;
  logic [rcr_pkg::CharW-1:0] out_char_q, out_char_d;
  logic [1:0] out_status_q, out_status_d;
  logic read_hit;

  assign read_hit = (rcr_pkg::CfgW'(read_col_i) <= rcr_pkg::CfgW'(last_col_i)) &&
                    (rcr_pkg::CfgW'(read_row_i) <= rcr_pkg::CfgW'(last_row_i));

  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    y_d          = y_q;
    err_d        = err_q;
    bounds_d     = bounds_q;
    fill_d       = fill_q;
    pchar_d      = pchar_q;
    rd_addr_d    = rd_addr_q;
    rd_hit_d     = rd_hit_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_char_d   = out_char_q;
    out_status_d = out_status_q;
    mem_we_o     = 1'b0;
    mem_re_o     = 1'b0;

    unique case (state_q)
      rcr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          x_d      = '0;
          y_d      = '0;
          rd_hit_d = 1'b0;
          status_d = rcr_pkg::STATUS_DONE;
          state_d  = rcr_pkg::ST_DONE;
          case (action_i)
            rcr_pkg::ACT_CLEAR: begin
              err_d   = 1'b0;
              pchar_d = bg_char_i;
              state_d = rcr_pkg::ST_CLEAR;
            end
            rcr_pkg::ACT_DRAW: begin
              if (err_q) begin
                status_d = rcr_pkg::STATUS_IGNORED;
              end else if (rect_span_x_i[rcr_pkg::CoordW-1] ||
                           rect_span_y_i[rcr_pkg::CoordW-1]) begin
                err_d    = 1'b1;
                status_d = rcr_pkg::STATUS_REJECT;
              end else begin
                bounds_d.left   = rcr_pkg::CalcW'(rect_left_i);
                bounds_d.top    = rcr_pkg::CalcW'(rect_top_i);
                bounds_d.right  = rcr_pkg::CalcW'(rect_left_i) +
                                  rcr_pkg::CalcW'(rect_span_x_i);
                bounds_d.bottom = rcr_pkg::CalcW'(rect_top_i) +
                                  rcr_pkg::CalcW'(rect_span_y_i);
                fill_d  = filled_i;
                pchar_d = paint_char_i;
                state_d = rcr_pkg::ST_DRAW;
              end
            end
            rcr_pkg::ACT_READ: begin
              if (read_hit) begin
                rd_addr_d = {RW'(read_row_i), CW'(read_col_i)};
                rd_hit_d  = 1'b1;
                state_d   = rcr_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      rcr_pkg::ST_CLEAR, rcr_pkg::ST_DRAW: begin
        mem_we_o = (state_q == rcr_pkg::ST_CLEAR) || paint_i;
        if (x_q == last_col_i) begin
          x_d = '0;
          if (y_q == last_row_i) begin
            state_d = rcr_pkg::ST_DONE;
          end else begin
            y_d = y_q + 1'b1;
          end
        end else begin
          x_d = x_q + 1'b1;
        end
      end
      rcr_pkg::ST_READ: begin
        mem_re_o = 1'b1;
        state_d  = rcr_pkg::ST_DONE;
      end
      rcr_pkg::ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_char_d   = rd_hit_q ? mem_rdata_i : '0;
          out_status_d = status_q;
          state_d      = rcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rcr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcr_pkg::ST_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bounds_q     <= bounds_d;
    fill_q       <= fill_d;
    pchar_q      <= pchar_d;
    rd_addr_q    <= rd_addr_d;
    rd_hit_q     <= rd_hit_d;
    status_q     <= status_d;
    out_char_q   <= out_char_d;
    out_status_q <= out_status_d;
  end

  assign in_stall_o  = (state_q != rcr_pkg::ST_IDLE);
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign bounds_o    = bounds_q;
  assign fill_o      = fill_q;
  assign mem_addr_o  = (state_q == rcr_pkg::ST_READ) ? rd_addr_q : {y_q, x_q};
  assign mem_wdata_o = pchar_q;
  assign out_valid_o = out_valid_q;
  assign cell_char_o = out_char_q;
  assign status_o    = out_status_q;

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == rcr_pkg::ST_DONE))
    else $error("result appeared without a finished item");

  a_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == rcr_pkg::ST_CLEAR || state_q == rcr_pkg::ST_DRAW))
    else $error("canvas written outside a walk");

  a_walk_in_canvas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcr_pkg::ST_CLEAR || state_q == rcr_pkg::ST_DRAW) |->
      (x_q <= last_col_i && y_q <= last_row_i))
    else $error("walk left the canvas in use");

  a_no_draw_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcr_pkg::ST_DRAW) |-> !err_q)
    else $error("draw walking while error is sticky");

  a_read_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcr_pkg::ST_READ) |=> (state_q == rcr_pkg::ST_DONE && rd_hit_q))
    else $error("cell read did not finish next cycle");

endmodule

>>> sv/rectangle_canvas_rasterizer.sv
// Top level of the rectangle canvas rasterizer: configuration and wiring.
//
// Keeps a character canvas of up to MAX_COLS by MAX_ROWS cells in one
// single-port memory with registered read, addressed {row, column}. Each item
// returns exactly one result. A clear item writes background_char to every
// cell in use and drops the sticky error; a draw item visits every cell in
// use and paints those inside the closed rectangle that lie less than one
// unit from an edge, or all inside cells when filled is set. Both walk the
// memory at one cell per cycle, and the item holds the block until the walk
// has covered every cell in use. A read item passes through the memory read
// state, and a rejected or ignored draw, a read outside the canvas or an
// unused action goes straight to the result. The block takes one item at a time;
// in_stall_o is low whenever it is idle, even while a result still waits in
// the output register. The canvas has no reset: clear it before reading.
// Width or height registers of 0 count as 1 and values above the maximum
// saturate. Write configuration only while no item is in flight.
module rectangle_canvas_rasterizer #(
  parameter int unsigned MAX_COLS = rcr_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS = rcr_pkg::MaxRowsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rcr_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [rcr_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_left_i,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_top_i,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_span_x_i,
  input  logic signed [rcr_pkg::CoordW-1:0]  rect_span_y_i,
  input  logic                               filled_i,
  input  logic [rcr_pkg::CharW-1:0]          paint_char_i,
  input  logic [rcr_pkg::PosW-1:0]           read_col_i,
  input  logic [rcr_pkg::PosW-1:0]           read_row_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rcr_pkg::CharW-1:0]          cell_char_o,
  output logic [1:0]                         status_o
);

  // column and row index widths; the memory is 2**(CW+RW) cells
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned AW = CW + RW;
  // widths that hold both a register value and the maximum size
  localparam int unsigned UseCW = ($clog2(MAX_COLS + 1) > rcr_pkg::CfgW) ?
                                  $clog2(MAX_COLS + 1) : rcr_pkg::CfgW;
  localparam int unsigned UseRW = ($clog2(MAX_ROWS + 1) > rcr_pkg::CfgW) ?
                                  $clog2(MAX_ROWS + 1) : rcr_pkg::CfgW;

  logic [rcr_pkg::CfgW-1:0]  width_q, height_q;
  logic [rcr_pkg::CharW-1:0] bg_q;
  logic [UseCW-1:0] cols_use;
  logic [UseRW-1:0] rows_use;
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;

  logic [CW-1:0] walk_x;
  logic [RW-1:0] walk_y;
  rcr_pkg::bounds_t bounds;
  logic fill, paint;
  logic [AW-1:0] mem_addr;
  logic mem_we, mem_re;
  logic [rcr_pkg::CharW-1:0] mem_wdata, mem_rdata;

  // Configuration registers; writes to unused indexes drop silently.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rcr_pkg::WidthReset;
      height_q <= rcr_pkg::HeightReset;
      bg_q     <= rcr_pkg::BgReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rcr_pkg::CFG_CANVAS_WIDTH:  width_q  <= cfg_wdata_i;
        rcr_pkg::CFG_CANVAS_HEIGHT: height_q <= cfg_wdata_i;
        rcr_pkg::CFG_BACKGROUND:    bg_q     <= cfg_wdata_i[rcr_pkg::CharW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the canvas size to 1..maximum.
  always_comb begin
    if (width_q == '0) begin
      cols_use = UseCW'(1);
    end else if (UseCW'(width_q) > UseCW'(MAX_COLS)) begin
      cols_use = UseCW'(MAX_COLS);
    end else begin
      cols_use = UseCW'(width_q);
    end
    if (height_q == '0) begin
      rows_use = UseRW'(1);
    end else if (UseRW'(height_q) > UseRW'(MAX_ROWS)) begin
      rows_use = UseRW'(MAX_ROWS);
    end else begin
      rows_use = UseRW'(height_q);
    end
  end

  assign last_col = CW'(cols_use - 1'b1);
  assign last_row = RW'(rows_use - 1'b1);

  rcr_walk_ctrl #(
    .CW (CW),
    .RW (RW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .rect_left_i   (rect_left_i),
    .rect_top_i    (rect_top_i),
    .rect_span_x_i (rect_span_x_i),
    .rect_span_y_i (rect_span_y_i),
    .filled_i      (filled_i),
    .paint_char_i  (paint_char_i),
    .read_col_i    (read_col_i),
    .read_row_i    (read_row_i),
    .last_col_i    (last_col),
    .last_row_i    (last_row),
    .bg_char_i     (bg_q),
    .x_o           (walk_x),
    .y_o           (walk_y),
    .bounds_o      (bounds),
    .fill_o        (fill),
    .paint_i       (paint),
    .mem_addr_o    (mem_addr),
    .mem_we_o      (mem_we),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_rdata_i   (mem_rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cell_char_o   (cell_char_o),
    .status_o      (status_o)
  );

  // Test the walk position against the latched rectangle.
  rcr_cell_classify #(
    .CW (CW),
    .RW (RW)
  ) u_classify (
    .x_i      (walk_x),
    .y_i      (walk_y),
    .bounds_i (bounds),
    .fill_i   (fill),
    .paint_o  (paint)
  );

  rcr_canvas_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .addr_i  (mem_addr),
    .we_i    (mem_we),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .rdata_o (mem_rdata)
  );

endmodule

>>> sim/rectangle_canvas_rasterizer_tb.sv
// Self-checking testbench of the rectangle canvas rasterizer: directed table, random phases.
module rectangle_canvas_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // codes the package leaves unnamed: spare register index and spare action
  localparam logic [rcr_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam logic [1:0]                  ACT_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_AFTER  = 30;   // results before the long output hold
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned BIG_CANVAS  = 4096; // cells above which a phase mostly reads

  typedef struct {
    logic [1:0]                        action;
    logic signed [rcr_pkg::CoordW-1:0] left;
    logic signed [rcr_pkg::CoordW-1:0] top;
    logic signed [rcr_pkg::CoordW-1:0] span_x;
    logic signed [rcr_pkg::CoordW-1:0] span_y;
    logic                              filled;
    logic [rcr_pkg::CharW-1:0]         paint;
    logic [rcr_pkg::PosW-1:0]          col;
    logic [rcr_pkg::PosW-1:0]          row;
  } canvas_item_t;

  typedef struct {
    logic [rcr_pkg::CharW-1:0] cell_char;
    logic [1:0]                status;
  } canvas_result_t;

  // one row of the directed table: a register write or an item
  typedef struct {
    bit                          is_cfg;
    logic [rcr_pkg::CfgIdxW-1:0] cfg_idx;
    logic [rcr_pkg::CfgW-1:0]    cfg_val;
    canvas_item_t                it;
    bit                          typed;
    logic [rcr_pkg::CharW-1:0]   want_cell;
    logic [1:0]                  want_status;
  } directed_row_t;

  typedef struct {
    logic [rcr_pkg::CfgW-1:0]  w;
    logic [rcr_pkg::CfgW-1:0]  h;
    logic [rcr_pkg::CharW-1:0] bg;
    int                        n;
  } canvas_phase_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rcr_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [rcr_pkg::CfgW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] action_i = rcr_pkg::ACT_CLEAR;
  logic signed [rcr_pkg::CoordW-1:0] rect_left_i = '0;
  logic signed [rcr_pkg::CoordW-1:0] rect_top_i = '0;
  logic signed [rcr_pkg::CoordW-1:0] rect_span_x_i = '0;
  logic signed [rcr_pkg::CoordW-1:0] rect_span_y_i = '0;
  logic filled_i = 1'b0;
  logic [rcr_pkg::CharW-1:0] paint_char_i = '0;
  logic [rcr_pkg::PosW-1:0] read_col_i = '0;
  logic [rcr_pkg::PosW-1:0] read_row_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [rcr_pkg::CharW-1:0] cell_char_o;
  logic [1:0] status_o;

  rectangle_canvas_rasterizer dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .action_i, .rect_left_i, .rect_top_i,
    .rect_span_x_i, .rect_span_y_i, .filled_i, .paint_char_i,
    .read_col_i, .read_row_i, .out_valid_o, .out_stall_i,
    .cell_char_o, .status_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block: canvas, sticky error and the three registers.
  logic [rcr_pkg::CharW-1:0] canvas_model [0:rcr_pkg::MaxColsDef*rcr_pkg::MaxRowsDef-1];
  bit                        halted_model = 1'b0;
  logic [rcr_pkg::CfgW-1:0]  width_model = rcr_pkg::WidthReset;
  logic [rcr_pkg::CfgW-1:0]  height_model = rcr_pkg::HeightReset;
  logic [rcr_pkg::CharW-1:0] bg_model = rcr_pkg::BgReset;

  canvas_result_t canvas_results_due[$];
  int unsigned    results_seen = 0;
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;
  bit             quiet = 1'b0;   // no idling on either side

  // A width or height of 0 counts as 1; larger than the memory saturates.
  function automatic int unsigned active_cols();
    if (width_model == 0) return 1;
    if (width_model > rcr_pkg::MaxColsDef) return rcr_pkg::MaxColsDef;
    return width_model;
  endfunction

  function automatic int unsigned active_rows();
    if (height_model == 0) return 1;
    if (height_model > rcr_pkg::MaxRowsDef) return rcr_pkg::MaxRowsDef;
    return height_model;
  endfunction

  // Advance the shadow canvas by one item and return the result it yields.
  function automatic canvas_result_t predict_canvas_result(canvas_item_t it);
    canvas_result_t r;
    int unsigned    cols;
    int unsigned    rows;
    longint         lx, ty, rx, by, px, py;
    bit             in_rect, band;
    r.cell_char = '0;
    r.status = rcr_pkg::STATUS_DONE;
    cols = active_cols();
    rows = active_rows();
    case (it.action)
      rcr_pkg::ACT_CLEAR: begin
        for (int y = 0; y < rows; y++)
          for (int x = 0; x < cols; x++)
            canvas_model[y*rcr_pkg::MaxColsDef + x] = bg_model;
        halted_model = 1'b0;
      end
      rcr_pkg::ACT_DRAW: begin
        if (halted_model) begin
          r.status = rcr_pkg::STATUS_IGNORED;
        end else if (it.span_x[rcr_pkg::CoordW-1] || it.span_y[rcr_pkg::CoordW-1]) begin
          halted_model = 1'b1;
          r.status = rcr_pkg::STATUS_REJECT;
        end else begin
          lx = longint'(it.left);
          ty = longint'(it.top);
          rx = lx + longint'(it.span_x);
          by = ty + longint'(it.span_y);
          for (int y = 0; y < rows; y++) begin
            for (int x = 0; x < cols; x++) begin
              px = longint'(x) * 256;
              py = longint'(y) * 256;
              in_rect = px >= lx && px <= rx && py >= ty && py <= by;
              // border band: less than one unit from any edge
              band = (px - lx < 256) || (py - ty < 256) ||
                     (rx - px < 256) || (by - py < 256);
              if (in_rect && (band || it.filled))
                canvas_model[y*rcr_pkg::MaxColsDef + x] = it.paint;
            end
          end
        end
      end
      rcr_pkg::ACT_READ: begin
        if (it.col < cols && it.row < rows)
          r.cell_char = canvas_model[it.row*rcr_pkg::MaxColsDef + it.col];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Item with every field random; callers fix the action and what it uses.
  function automatic canvas_item_t random_fields();
    canvas_item_t it;
    it.action = 2'($urandom);
    it.left   = rcr_pkg::CoordW'($urandom);
    it.top    = rcr_pkg::CoordW'($urandom);
    it.span_x = rcr_pkg::CoordW'($urandom);
    it.span_y = rcr_pkg::CoordW'($urandom);
    it.filled = 1'($urandom);
    it.paint  = rcr_pkg::CharW'($urandom);
    it.col    = rcr_pkg::PosW'($urandom);
    it.row    = rcr_pkg::PosW'($urandom);
    return it;
  endfunction

  function automatic canvas_item_t random_read();
    canvas_item_t it;
    it = random_fields();
    it.action = rcr_pkg::ACT_READ;
    // mostly cells in use; every cell in use was written by the phase clear
    if ($urandom_range(0, 9) < 7) begin
      it.col = rcr_pkg::PosW'($urandom_range(0, active_cols() - 1));
      it.row = rcr_pkg::PosW'($urandom_range(0, active_rows() - 1));
    end
    return it;
  endfunction

  function automatic canvas_item_t random_draw();
    canvas_item_t it;
    int unsigned  sel;
    int unsigned  cols;
    int unsigned  rows;
    it = random_fields();
    it.action = rcr_pkg::ACT_DRAW;
    sel = $urandom_range(0, 99);
    cols = active_cols();
    rows = active_rows();
    if (sel < 10) begin
      // raw noise: coordinates anywhere, either sign
    end else if (sel < 16) begin
      if ($urandom_range(0, 1) == 1) it.span_x[rcr_pkg::CoordW-1] = 1'b1;
      else it.span_y[rcr_pkg::CoordW-1] = 1'b1;
    end else begin
      // well-formed rectangle around the canvas, fractions random
      it.left = rcr_pkg::CoordW'(int'($urandom_range(0, (cols + 4) * 256)) - 512);
      it.top  = rcr_pkg::CoordW'(int'($urandom_range(0, (rows + 4) * 256)) - 512);
      if (sel < 30) begin
        it.span_x = rcr_pkg::CoordW'($urandom_range(0, 767));
        it.span_y = rcr_pkg::CoordW'($urandom_range(0, 767));
      end else begin
        it.span_x = rcr_pkg::CoordW'($urandom_range(0, (cols + 2) * 256));
        it.span_y = rcr_pkg::CoordW'($urandom_range(0, (rows + 2) * 256));
      end
    end
    return it;
  endfunction

  function automatic canvas_item_t random_item();
    canvas_item_t it;
    int unsigned  sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      it = random_fields();
      it.action = rcr_pkg::ACT_CLEAR;
    end else if (sel < 55) begin
      it = random_draw();
    end else if (sel < 95) begin
      it = random_read();
    end else begin
      it = random_fields();
      it.action = ACT_UNUSED;
    end
    return it;
  endfunction

  function automatic canvas_item_t mk_item(logic [1:0] act, logic [rcr_pkg::CoordW-1:0] l,
                                           logic [rcr_pkg::CoordW-1:0] t,
                                           logic [rcr_pkg::CoordW-1:0] sx,
                                           logic [rcr_pkg::CoordW-1:0] sy, logic f,
                                           logic [rcr_pkg::CharW-1:0] c,
                                           logic [rcr_pkg::PosW-1:0] col,
                                           logic [rcr_pkg::PosW-1:0] row);
    canvas_item_t it;
    it.action = act;
    it.left = l;
    it.top = t;
    it.span_x = sx;
    it.span_y = sy;
    it.filled = f;
    it.paint = c;
    it.col = col;
    it.row = row;
    return it;
  endfunction

  function automatic directed_row_t item_row(canvas_item_t it, bit typed,
                                             logic [rcr_pkg::CharW-1:0] exp_char,
                                             logic [1:0] status);
    directed_row_t d;
    d.is_cfg = 1'b0;
    d.cfg_idx = '0;
    d.cfg_val = '0;
    d.it = it;
    d.typed = typed;
    d.want_cell = exp_char;
    d.want_status = status;
    return d;
  endfunction

  function automatic directed_row_t cfg_row(logic [rcr_pkg::CfgIdxW-1:0] idx,
                                            logic [rcr_pkg::CfgW-1:0] val);
    directed_row_t d;
    d = item_row(mk_item(rcr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0,
                 rcr_pkg::STATUS_DONE);
    d.is_cfg = 1'b1;
    d.cfg_idx = idx;
    d.cfg_val = val;
    return d;
  endfunction

  // All tasks below are entered and left at a falling edge.

  // Write one register; the block is idle here, so the shadow follows at once.
  task automatic write_cfg(input logic [rcr_pkg::CfgIdxW-1:0] idx,
                           input logic [rcr_pkg::CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      rcr_pkg::CFG_CANVAS_WIDTH:  width_model = val;
      rcr_pkg::CFG_CANVAS_HEIGHT: height_model = val;
      rcr_pkg::CFG_BACKGROUND:    bg_model = val[rcr_pkg::CharW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one item, hold it until taken, then queue its expected result.
  task automatic push_item(input canvas_item_t it, input bit typed,
                           input logic [rcr_pkg::CharW-1:0] exp_char,
                           input logic [1:0] status);
    canvas_result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= it.action;
    rect_left_i <= it.left;
    rect_top_i <= it.top;
    rect_span_x_i <= it.span_x;
    rect_span_y_i <= it.span_y;
    filled_i <= it.filled;
    paint_char_i <= it.paint;
    read_col_i <= it.col;
    read_row_i <= it.row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = predict_canvas_result(it);
    if (typed) begin
      r.cell_char = exp_char;
      r.status = status;
    end
    canvas_results_due.push_back(r);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every result is back and the block is idle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (canvas_results_due.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Receiver: random stall bursts, one long hold to back the block up, and
  // no stalls at all once the run turns quiet.
  int unsigned stall_left = 0;
  int unsigned run_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (run_left > 0 || quiet) begin
      if (run_left > 0) run_left--;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_stall_i <= 1'b1;
    end else begin
      // now and then a long stretch with no stall
      run_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 24) - 1;
      out_stall_i <= 1'b0;
    end
  end

  // Compare every result taken against the oldest expectation.
  always @(posedge clk_i) begin
    canvas_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (canvas_results_due.size() == 0) begin
        $display("%0t: result with none expected: cell_char %h status %0d",
                 $time, cell_char_o, status_o);
        error_count++;
      end else begin
        e = canvas_results_due.pop_front();
        if (cell_char_o !== e.cell_char) begin
          $display("%0t: cell_char expected %h actual %h", $time, e.cell_char, cell_char_o);
          error_count++;
        end
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          error_count++;
        end
      end
      results_seen++;
    end
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  directed_row_t directed_rows[$];
  canvas_phase_t phase_plan[$];

  initial begin
    canvas_item_t it;
    bit           big;
    // Directed table. Starts on the reset canvas (1x1, space background),
    // then a 12x9 canvas with '.' background.
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0),
                                     1'b1, 8'h00, rcr_pkg::STATUS_DONE));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0),
                                     1'b1, 8'h20, rcr_pkg::STATUS_DONE));
    // outside the canvas in both directions
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 255, 255),
                                     1'b1, 8'h00, rcr_pkg::STATUS_DONE));
    // unused action with every field at its top value
    directed_rows.push_back(item_row(mk_item(ACT_UNUSED, 24'hFFFFFF, 24'hFFFFFF,
                                             24'hFFFFFF, 24'hFFFFFF, 1, 8'hFF, 255, 255),
                                     1'b1, 8'h00, rcr_pkg::STATUS_DONE));
    directed_rows.push_back(cfg_row(rcr_pkg::CFG_CANVAS_WIDTH, 9'd12));
    directed_rows.push_back(cfg_row(rcr_pkg::CFG_CANVAS_HEIGHT, 9'd9));
    directed_rows.push_back(cfg_row(rcr_pkg::CFG_BACKGROUND, 9'h02E));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0),
                                     1'b1, 8'h00, rcr_pkg::STATUS_DONE));
    // last cell in use, then one past each edge
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 11, 8),
                                     1'b1, 8'h2E, rcr_pkg::STATUS_DONE));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 12, 0),
                                     1'b1, 8'h00, rcr_pkg::STATUS_DONE));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 9),
                                     1'b1, 8'h00, rcr_pkg::STATUS_DONE));
    // outline, filled with fractional edges, zero-size point
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_DRAW, 24'd512, 24'd256, 24'd1280,
                                             24'd1024, 0, "R", 0, 0), 1'b0, 0, 0));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_DRAW, 24'd128, -24'sd64, 24'd832,
                                             24'd832, 1, "r", 0, 0), 1'b0, 0, 0));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_DRAW, 24'd768, 24'd768, 0, 0, 0,
                                             "#", 0, 0), 1'b0, 0, 0));
    // extreme coordinates: far left with widest span, far right corner
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_DRAW, 24'h800000, 24'h800000,
                                             24'h7FFFFF, 24'h7FFFFF, 1, "X", 0, 0),
                                     1'b0, 0, 0));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_DRAW, 24'h7FFFFF, 24'h7FFFFF, 0, 0,
                                             1, "Y", 0, 0), 1'b0, 0, 0));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_DRAW, 0, 0, 24'd2816, 24'd2048, 0,
                                             "B", 0, 0), 1'b0, 0, 0));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 2, 1),
                                     1'b0, 0, 0));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 3, 3),
                                     1'b0, 0, 0));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 5, 5),
                                     1'b0, 0, 0));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0),
                                     1'b0, 0, 0));
    // negative width rejects; later draws are ignored until the next clear
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_DRAW, 0, 0, 24'hFFFFFF, 24'd256,
                                             1, "E", 0, 0),
                                     1'b1, 8'h00, rcr_pkg::STATUS_REJECT));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_DRAW, 0, 0, 24'd512, 24'd512, 1,
                                             "I", 0, 0),
                                     1'b1, 8'h00, rcr_pkg::STATUS_IGNORED));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_DRAW, 0, 0, 24'd256, 24'h800000,
                                             0, "I", 0, 0),
                                     1'b1, 8'h00, rcr_pkg::STATUS_IGNORED));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 2, 1),
                                     1'b0, 0, 0));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0),
                                     1'b1, 8'h00, rcr_pkg::STATUS_DONE));
    // most negative height right after a clear
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_DRAW, 0, 0, 24'd256, 24'h800000,
                                             0, "E", 0, 0),
                                     1'b1, 8'h00, rcr_pkg::STATUS_REJECT));
    directed_rows.push_back(item_row(mk_item(rcr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0),
                                     1'b1, 8'h00, rcr_pkg::STATUS_DONE));

    // Random phases: small canvases mostly, size extremes and saturation,
    // one full canvas, and a last phase with no idling.
    phase_plan.push_back('{9'd8,   9'd6,   rcr_pkg::CharW'($urandom), 16});
    phase_plan.push_back('{9'd1,   9'd1,   8'h00,                     6});
    phase_plan.push_back('{9'd0,   9'd0,   8'hFF,                     6});
    phase_plan.push_back('{9'd20,  9'd13,  rcr_pkg::CharW'($urandom), 12});
    phase_plan.push_back('{9'd511, 9'd2,   rcr_pkg::CharW'($urandom), 8});
    phase_plan.push_back('{9'd3,   9'd300, rcr_pkg::CharW'($urandom), 8});
    phase_plan.push_back('{9'd256, 9'd256, rcr_pkg::CharW'($urandom), 5});
    phase_plan.push_back('{9'd16,  9'd10,  rcr_pkg::CharW'($urandom), 10});

    // Hold reset, then release it on a falling edge.
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_drained();
        write_cfg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
      end else begin
        push_item(directed_rows[i].it, directed_rows[i].typed,
                  directed_rows[i].want_cell, directed_rows[i].want_status);
      end
    end

    foreach (phase_plan[p]) begin
      wait_drained();
      if (p == phase_plan.size() - 1) quiet = 1'b1;
      write_cfg(rcr_pkg::CFG_CANVAS_WIDTH, phase_plan[p].w);
      write_cfg(rcr_pkg::CFG_CANVAS_HEIGHT, phase_plan[p].h);
      write_cfg(rcr_pkg::CFG_BACKGROUND, rcr_pkg::CfgW'(phase_plan[p].bg));
      // the spare index holds no register
      if (p == 1) write_cfg(CFG_UNUSED, rcr_pkg::CfgW'($urandom));
      big = active_cols() * active_rows() > BIG_CANVAS;
      // Start each phase with a clear so every cell in use holds a value.
      it = random_fields();
      it.action = rcr_pkg::ACT_CLEAR;
      push_item(it, 1'b0, '0, rcr_pkg::STATUS_DONE);
      for (int k = 0; k < phase_plan[p].n; k++) begin
        // on the full canvas one draw, then reads only, to keep the run short
        if (big) it = (k == 0) ? random_draw() : random_read();
        else it = random_item();
        push_item(it, 1'b0, '0, rcr_pkg::STATUS_DONE);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/rcr_pkg.sv
sv/rcr_canvas_mem.sv
sv/rcr_cell_classify.sv
sv/rcr_walk_ctrl.sv
sv/rectangle_canvas_rasterizer.sv
sim/rectangle_canvas_rasterizer_tb.sv
